// ----- hdl/isort_pkg.sv -----
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sorter: controller commands and datapath
// status.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;   // insert the input value (or drop it when full)
    logic shift;    // move every entry down one place, head leaves
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_one; // exactly one entry left in the store
  } dp_status_t;

endpackage

// ----- hdl/isort_in_if.sv -----
// ----------------------------------------------------------------------------
// isort_in_if
// Input channel of the insertion sorter: one value per item.
// ----------------------------------------------------------------------------
interface isort_in_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::data_t     value;
  logic                 is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ----- hdl/isort_out_if.sv -----
// ----------------------------------------------------------------------------
// isort_out_if
// Output channel of the insertion sorter: one sorted value per item.
// ----------------------------------------------------------------------------
interface isort_out_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::data_t     sorted_value;
  logic                 end_of_set;
  logic                 overflow;

  modport source (output valid, output sorted_value, output end_of_set,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set,
                  input overflow, output ready);
endinterface

// ----- hdl/isort_ctrl.sv -----
// ----------------------------------------------------------------------------
// isort_ctrl
// Controller: takes items while filling, then drains the sorted store.
// ----------------------------------------------------------------------------
module isort_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_is_last,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output isort_pkg::dp_cmd_t    cmd,
  input  isort_pkg::dp_status_t status
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (in_is_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (status.last_one) begin
            state_next = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/isort_dp.sv -----
// ----------------------------------------------------------------------------
// isort_dp
// Datapath: a row of compare cells holding the sorted store, the fill count
// and the drop flag.
// ----------------------------------------------------------------------------
module isort_dp #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  isort_pkg::dp_cmd_t    cmd,
  output isort_pkg::dp_status_t status,
  input  isort_pkg::data_t      value,
  output isort_pkg::data_t      sorted_value,
  output logic                  end_of_set,
  output logic                  overflow
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  isort_pkg::data_t        store [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] gt;
  logic [CW-1:0]           count;
  logic                    dropped;
  logic                    full;
  logic                    do_insert;

  assign full      = (count == CNT_MAX);
  assign do_insert = cmd.insert && !full;

  // Each cell compares its entry with the new value. Strictly greater
  // entries move up, so equal values keep arrival order.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    assign gt[i] = (IDX < count) && (store[i] > value);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (gt[i] || (IDX == count)) begin
            store[i] <= value;
          end
        end else if (cmd.shift) begin
          store[i] <= store[i+1];
        end
      end
    end else if (i == MAX_ELEMENTS - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (gt[i-1]) begin
            store[i] <= store[i-1];
          end else if (gt[i] || (IDX == count)) begin
            store[i] <= value;
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (gt[i-1]) begin
            store[i] <= store[i-1];
          end else if (gt[i] || (IDX == count)) begin
            store[i] <= value;
          end
        end else if (cmd.shift) begin
          store[i] <= store[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_ONE;
      end
    end else if (cmd.shift) begin
      count <= count - CNT_ONE;
      if (count == CNT_ONE) begin
        dropped <= 1'b0;
      end
    end
  end

  assign status.last_one = (count == CNT_ONE);
  assign sorted_value    = store[0];
  assign end_of_set      = (count == CNT_ONE);
  assign overflow        = dropped;

endmodule

// ----- hdl/insertion_sorter_top.sv -----
// The first sorted result is valid in the cycle after the last item is accepted.
// One input item per cycle while filling; every cell compares in parallel.
// A set of n results drains at one per cycle when the sink is ready; no item is
// accepted during the drain.
// Reset clears the fill count, the drop flag and the controller; store contents
// are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Streaming insertion sorter of signed 32-bit values with overflow reporting.
// ----------------------------------------------------------------------------
module insertion_sorter_top #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  isort_in_if.sink    in_ch,
  isort_out_if.source out_ch
);

  isort_pkg::dp_cmd_t    cmd;
  isort_pkg::dp_status_t status;

  isort_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.is_last),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .status     (status)
  );

  isort_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (in_ch.value),
    .sorted_value (out_ch.sorted_value),
    .end_of_set   (out_ch.end_of_set),
    .overflow     (out_ch.overflow)
  );

  // filling and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while results pending");

  // a last item always opens a drain on the next cycle
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.is_last) |=> out_ch.valid)
    else $error("no result after last item");

  // the final result of a set returns the block to filling
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.end_of_set) |=>
      (!out_ch.valid && in_ch.ready))
    else $error("drain did not end after end of set");

  // every drained item comes from a shift command
  a_shift_on_fire: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |-> (cmd.shift && !cmd.insert))
    else $error("result taken without shift");

endmodule

// ----- verif/isort_order_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_order_checker
// Watches both channels of the insertion sorter. Keeps its own sorted store,
// works out the sorted set for every item marked last, and compares each
// sorted item leaving the block with the oldest one still expected.
// ----------------------------------------------------------------------------
module isort_order_checker #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic  clk,
  input  logic  rst,
  isort_in_if   in_mon,
  isort_out_if  out_mon,
  output int    mismatches,
  output int    waiting,
  output int    results_checked
);

  typedef struct packed {
    isort_pkg::data_t value;
    logic             end_of_set;
    logic             overflow;
  } sorted_item_t;

  isort_pkg::data_t sort_store [MAX_ELEMENTS];
  int unsigned      fill;
  bit               dropped;
  sorted_item_t     expected_sorted [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Larger entries move up, so equal values stay in arrival order.
  task automatic insert_value(isort_pkg::data_t v, logic last);
    int unsigned  pos;
    sorted_item_t r;
    if (fill < MAX_ELEMENTS) begin
      pos = fill;
      while (pos > 0 && sort_store[pos-1] > v) begin
        sort_store[pos] = sort_store[pos-1];
        pos--;
      end
      sort_store[pos] = v;
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < fill; k++) begin
        r.value      = sort_store[k];
        r.end_of_set = (k + 1 == fill);
        r.overflow   = dropped;
        expected_sorted.push_back(r);
      end
      fill    = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_sorted();
    sorted_item_t e;
    results_checked++;
    if (expected_sorted.size() == 0) begin
      report_mismatch($sformatf("sorted item %0d with nothing expected",
                                out_mon.sorted_value));
    end else begin
      e = expected_sorted.pop_front();
      if (out_mon.sorted_value !== e.value)
        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                  out_mon.sorted_value, e.value));
      if (out_mon.end_of_set !== e.end_of_set)
        report_mismatch($sformatf("end_of_set %b, expected %b (value %0d)",
                                  out_mon.end_of_set, e.end_of_set, e.value));
      if (out_mon.overflow !== e.overflow)
        report_mismatch($sformatf("overflow %b, expected %b (value %0d)",
                                  out_mon.overflow, e.overflow, e.value));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill            = 0;
      dropped         = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      expected_sorted.delete();
    end else begin
      // output first: a result can never come from the item taken this edge
      if (out_mon.valid && out_mon.ready)
        check_sorted();
      if (in_mon.valid && in_mon.ready)
        insert_value(in_mon.value, in_mon.is_last);
    end
    waiting <= expected_sorted.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the insertion sorter: directed sets for the value
// extremes and a store overflow, then random sets under three idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned      MAX_ELEMENTS = 16;
  localparam int unsigned      CYCLE_LIMIT  = 100000;
  localparam isort_pkg::data_t MOST_NEG     = 32'sh8000_0000;
  localparam isort_pkg::data_t MOST_POS     = 32'sh7fff_ffff;

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt     = 0;
  int          items_sent    = 0;
  int          sets_sent     = 0;
  int          drop_sets     = 0;
  int          mismatches;
  int          waiting;
  int          results_checked;

  isort_in_if  in_ch ();
  isort_out_if out_ch ();

  insertion_sorter_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  isort_order_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_order_chk (
    .clk             (clk),
    .rst             (rst),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .waiting         (waiting),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sorted items still due",
               cycle_cnt, waiting);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Half random, with small values for ties and the field extremes.
  function automatic isort_pkg::data_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return isort_pkg::data_t'($urandom);
    if (r < 80) return isort_pkg::data_t'(int'($urandom_range(8)) - 4);
    case ($urandom_range(3))
      0:       return MOST_NEG;
      1:       return MOST_NEG + 1;
      2:       return MOST_POS - 1;
      default: return MOST_POS;
    endcase
  endfunction

  // Small sets give more sets per run; some fill the store or overrun it.
  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 80) return $urandom_range(7, MAX_ELEMENTS - 1);
    if (r < 92) return MAX_ELEMENTS;
    return $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
  endfunction

  task automatic send_item(isort_pkg::data_t v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_set(int n);
    for (int k = 0; k < n; k++)
      send_item(pick_value(), k == n - 1);
    sets_sent++;
    if (n > MAX_ELEMENTS) drop_sets++;
  endtask

  // Sender holds off until every sorted item due has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  initial begin
    isort_pkg::data_t spread [7];
    spread = '{32'sd5, -32'sd3, 32'sd5, MOST_POS, MOST_NEG, -32'sd1, 32'sd0};

    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.is_last <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 75;

    // one-item set
    send_item(MOST_NEG, 1'b1);
    sets_sent++;
    // extremes, ties and a zero
    foreach (spread[k])
      send_item(spread[k], k == 6);
    sets_sent++;
    // descending values shift the whole store; the last item is dropped
    for (int k = 0; k <= MAX_ELEMENTS; k++)
      send_item(isort_pkg::data_t'(100 - 7 * k), k == MAX_ELEMENTS);
    sets_sent++;
    drop_sets++;
    wait_drained();

    while (items_sent < 87) send_set(pick_set_size());
    wait_drained();
    send_idle_pct = 75;
    recv_idle_pct = 18;
    while (items_sent < 149) send_set(pick_set_size());
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 210) send_set(pick_set_size());

    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d items in %0d sets, %0d of them overran the store",
             items_sent, sets_sent, drop_sets);
    $display("checked %0d sorted items under three idling mixes",
             results_checked);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
